// ===== src/ebmh_pkg.sv =====
package ebmh_pkg;

   // heap geometry
   localparam int CAPACITY    = 1024;
   localparam int ADDR_BITS   = $clog2(CAPACITY);
   localparam int COUNT_BITS  = $clog2(CAPACITY + 1);
   localparam int VERTEX_BITS = 16;
   localparam int WEIGHT_BITS = 16;
   localparam int ENTRY_BITS  = 2 * VERTEX_BITS + WEIGHT_BITS;

   // stream word layout
   localparam int REQ_DATA_BITS = ((ENTRY_BITS + 7) / 8) * 8;
   localparam int RSP_PAY_BITS  = ENTRY_BITS + COUNT_BITS;
   localparam int RSP_DATA_BITS = ((RSP_PAY_BITS + 7) / 8) * 8;
   localparam int STATUS_BITS   = 2;

   // register port
   localparam int CSR_ADDR_BITS = 2;
   localparam int CSR_DATA_BITS = 32;
   localparam logic [CSR_ADDR_BITS-1:0] CSR_CAPACITY_LIMIT = 2'd0;
   localparam logic [COUNT_BITS-1:0]    LIMIT_RESET = COUNT_BITS'(CAPACITY);

   // commands
   localparam logic CMD_INSERT = 1'b0;
   localparam logic CMD_DELETE = 1'b1;

   // result status codes
   localparam logic [STATUS_BITS-1:0] STATUS_DONE  = 2'd0;
   localparam logic [STATUS_BITS-1:0] STATUS_FULL  = 2'd1;
   localparam logic [STATUS_BITS-1:0] STATUS_EMPTY = 2'd2;

   typedef struct packed {
      logic signed [WEIGHT_BITS-1:0] weight;
      logic [VERTEX_BITS-1:0]        w;
      logic [VERTEX_BITS-1:0]        v;
   } entry_type;

   typedef struct packed {
      logic [STATUS_BITS-1:0] status;
      entry_type              min_edge;
      logic [COUNT_BITS-1:0]  occupancy;
   } result_type;

   // memory access from the sift engine
   typedef struct packed {
      logic                 wr_en;
      logic [ADDR_BITS-1:0] wr_addr;
      entry_type            wr_data;
      logic [ADDR_BITS-1:0] rd_addr_a;
      logic [ADDR_BITS-1:0] rd_addr_b;
   } ram_req_type;

endpackage

// ===== src/edge_binary_min_heap.sv =====
// Binary min-heap of graph edges keyed by signed weight.
// req channel: one word per command. tuser is the command (insert or
// delete-min); tdata carries the edge for an insert and is ignored on delete.
// rsp channel: exactly one word per command, in command order. tuser is the
// status (done, full on insert, empty on delete); tdata holds the removed
// edge (zero for inserts and refused commands) and the occupancy afterwards.
// csr port: register 0 at byte address 0 is capacity_limit; an insert is
// refused once the heap holds min(capacity_limit, 1024) entries.
// A refused command goes straight to the result. An insert climbs from the
// new last slot toward the root; a delete fetches the root and the last entry
// together and, unless that leaves the heap empty, sinks that entry from the
// root. Each level is one read and one compare-and-write on the heap memory
// (one write port, two read ports); the final write at the root or at a leaf
// needs no read. The next command is taken in the cycle after the previous
// result enters the output register. That register holds while rsp_tready is
// low, and a further finished result waits in the sequencer, which then stalls
// req_tready.
// Reset empties the heap and sets capacity_limit to 1024; the memory itself
// is not cleared, since only written entries are ever used.
module edge_binary_min_heap (
   input  logic                                clock,
   input  logic                                reset,
   // command words
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic                                req_tuser,   // cmd
   input  logic [ebmh_pkg::REQ_DATA_BITS-1:0]  req_tdata,   // edge_v, edge_w, edge_weight
   // result words
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [ebmh_pkg::STATUS_BITS-1:0]    rsp_tuser,   // status
   output logic [ebmh_pkg::RSP_DATA_BITS-1:0]  rsp_tdata,   // min_v, min_w, min_weight,
                                                            // occupancy, zero pad
   // register port
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [ebmh_pkg::CSR_ADDR_BITS-1:0]  csr_paddr,
   input  logic [ebmh_pkg::CSR_DATA_BITS-1:0]  csr_pwdata,
   output logic [ebmh_pkg::CSR_DATA_BITS-1:0]  csr_prdata,
   output logic                                csr_pready
);

   logic [ebmh_pkg::COUNT_BITS-1:0] limit_ff, limit_in;
   logic                            rsp_valid_ff, rsp_valid_in;
   ebmh_pkg::result_type            rsp_ff, rsp_in;

   ebmh_pkg::entry_type             cmd_entry;
   logic                            res_valid;
   logic                            res_take;
   ebmh_pkg::result_type            res;
   ebmh_pkg::ram_req_type           ram_req;
   logic [ebmh_pkg::ENTRY_BITS-1:0] rd_data_a;
   logic [ebmh_pkg::ENTRY_BITS-1:0] rd_data_b;

   // register port
   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr == ebmh_pkg::CSR_CAPACITY_LIMIT)
                     ? ebmh_pkg::CSR_DATA_BITS'(limit_ff) : '0;

   always_comb begin
      limit_in = limit_ff;
      if (csr_psel && csr_penable && csr_pwrite && csr_pready &&
          csr_paddr == ebmh_pkg::CSR_CAPACITY_LIMIT) begin
         limit_in = csr_pwdata[ebmh_pkg::COUNT_BITS-1:0];
      end
   end

   // unpack command word
   assign cmd_entry.v      = req_tdata[ebmh_pkg::VERTEX_BITS-1:0];
   assign cmd_entry.w      = req_tdata[2*ebmh_pkg::VERTEX_BITS-1:ebmh_pkg::VERTEX_BITS];
   assign cmd_entry.weight = req_tdata[ebmh_pkg::ENTRY_BITS-1:2*ebmh_pkg::VERTEX_BITS];

   ebmh_engine u_engine (
      .clock     (clock),
      .reset     (reset),
      .cmd_valid (req_tvalid),
      .cmd_ready (req_tready),
      .cmd_op    (req_tuser),
      .cmd_entry (cmd_entry),
      .limit     (limit_ff),
      .res_valid (res_valid),
      .res_take  (res_take),
      .res       (res),
      .ram_req   (ram_req),
      .rd_data_a (rd_data_a),
      .rd_data_b (rd_data_b)
   );

   ebmh_ram #(
      .WIDTH (ebmh_pkg::ENTRY_BITS),
      .DEPTH (ebmh_pkg::CAPACITY),
      .ABITS (ebmh_pkg::ADDR_BITS)
   ) u_ram (
      .clock     (clock),
      .wr_en     (ram_req.wr_en),
      .wr_addr   (ram_req.wr_addr),
      .wr_data   (ram_req.wr_data),
      .rd_addr_a (ram_req.rd_addr_a),
      .rd_addr_b (ram_req.rd_addr_b),
      .rd_data_a (rd_data_a),
      .rd_data_b (rd_data_b)
   );

   // output register
   assign res_take = res_valid && (!rsp_valid_ff || rsp_tready);

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      if (res_take) begin
         rsp_valid_in = 1'b1;
         rsp_in       = res;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff     <= ebmh_pkg::LIMIT_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         limit_ff     <= limit_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_ff.status;
   assign rsp_tdata  = ebmh_pkg::RSP_DATA_BITS'({rsp_ff.occupancy, rsp_ff.min_edge.weight,
                                                 rsp_ff.min_edge.w, rsp_ff.min_edge.v});

endmodule

// ===== src/ebmh_ram.sv =====
// one write port, two read ports, read data registered
module ebmh_ram #(
   parameter int WIDTH = 48,
   parameter int DEPTH = 1024,
   parameter int ABITS = $clog2(DEPTH)
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [ABITS-1:0] wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [ABITS-1:0] rd_addr_a,
   input  logic [ABITS-1:0] rd_addr_b,
   output logic [WIDTH-1:0] rd_data_a,
   output logic [WIDTH-1:0] rd_data_b
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_a <= mem[rd_addr_a];
      rd_data_b <= mem[rd_addr_b];
   end

endmodule

// ===== src/ebmh_engine.sv =====
// Command sequencer: sift-up for insert, sift-down for delete-min.
// No read is issued in the same cycle as a write to the memory, so no
// forwarding is needed.
module ebmh_engine (
   input  logic                           clock,
   input  logic                           reset,
   // command in
   input  logic                           cmd_valid,
   output logic                           cmd_ready,
   input  logic                           cmd_op,
   input  ebmh_pkg::entry_type            cmd_entry,
   input  logic [ebmh_pkg::COUNT_BITS-1:0] limit,
   // result out
   output logic                           res_valid,
   input  logic                           res_take,
   output ebmh_pkg::result_type           res,
   // memory
   output ebmh_pkg::ram_req_type          ram_req,
   input  ebmh_pkg::entry_type            rd_data_a,
   input  ebmh_pkg::entry_type            rd_data_b
);

   typedef enum logic [6:0] {
      S_IDLE    = 7'b0000001,
      S_UP_RD   = 7'b0000010,
      S_UP_CMP  = 7'b0000100,
      S_DN_ROOT = 7'b0001000,
      S_DN_RD   = 7'b0010000,
      S_DN_CMP  = 7'b0100000,
      S_DONE    = 7'b1000000
   } state_type;

   state_type                              state_ff, state_in;
   logic [ebmh_pkg::ADDR_BITS-1:0]         pos_ff, pos_in;
   ebmh_pkg::entry_type                    item_ff, item_in;
   ebmh_pkg::entry_type                    top_ff, top_in;
   logic [ebmh_pkg::STATUS_BITS-1:0]       status_ff, status_in;
   logic [ebmh_pkg::COUNT_BITS-1:0]        count_ff, count_in;

   logic [ebmh_pkg::ADDR_BITS-1:0]         parent_addr;
   logic [ebmh_pkg::ADDR_BITS:0]           left_idx;
   logic [ebmh_pkg::ADDR_BITS:0]           right_idx;
   logic                                   left_in_heap;
   logic                                   right_in_heap;
   logic                                   pick_right;
   ebmh_pkg::entry_type                    chosen;
   logic [ebmh_pkg::ADDR_BITS-1:0]         chosen_addr;
   logic                                   is_full;

   // tree navigation
   assign parent_addr   = (pos_ff - ebmh_pkg::ADDR_BITS'(1)) >> 1;
   assign left_idx      = {pos_ff, 1'b1};
   assign right_idx     = left_idx + (ebmh_pkg::ADDR_BITS + 1)'(1);
   assign left_in_heap  = (ebmh_pkg::COUNT_BITS + 1)'(left_idx) < {1'b0, count_ff};
   assign right_in_heap = (ebmh_pkg::COUNT_BITS + 1)'(right_idx) < {1'b0, count_ff};

   // right child only when the left one is strictly heavier
   assign pick_right  = right_in_heap && ($signed(rd_data_a.weight) > $signed(rd_data_b.weight));
   assign chosen      = pick_right ? rd_data_b : rd_data_a;
   assign chosen_addr = pick_right ? right_idx[ebmh_pkg::ADDR_BITS-1:0]
                                   : left_idx[ebmh_pkg::ADDR_BITS-1:0];

   assign is_full = (count_ff >= limit) ||
                    (count_ff >= ebmh_pkg::COUNT_BITS'(ebmh_pkg::CAPACITY));

   // next-state logic
   always_comb begin
      state_in  = state_ff;
      pos_in    = pos_ff;
      item_in   = item_ff;
      top_in    = top_ff;
      status_in = status_ff;
      count_in  = count_ff;
      ram_req   = '0;
      cmd_ready = 1'b0;
      res_valid = 1'b0;
      case (state_ff)
         S_IDLE: begin
            cmd_ready = 1'b1;
            if (cmd_valid) begin
               top_in    = '0;
               status_in = ebmh_pkg::STATUS_DONE;
               if (cmd_op == ebmh_pkg::CMD_INSERT) begin
                  if (is_full) begin
                     status_in = ebmh_pkg::STATUS_FULL;
                     state_in  = S_DONE;
                  end else begin
                     item_in  = cmd_entry;
                     pos_in   = count_ff[ebmh_pkg::ADDR_BITS-1:0];
                     count_in = count_ff + ebmh_pkg::COUNT_BITS'(1);
                     state_in = S_UP_RD;
                  end
               end else begin
                  if (count_ff == '0) begin
                     status_in = ebmh_pkg::STATUS_EMPTY;
                     state_in  = S_DONE;
                  end else begin
                     // fetch root and last entry together
                     ram_req.rd_addr_a = '0;
                     ram_req.rd_addr_b = ebmh_pkg::ADDR_BITS'(count_ff - ebmh_pkg::COUNT_BITS'(1));
                     count_in = count_ff - ebmh_pkg::COUNT_BITS'(1);
                     state_in = S_DN_ROOT;
                  end
               end
            end
         end
         S_UP_RD: begin
            if (pos_ff == '0) begin
               ram_req.wr_en   = 1'b1;
               ram_req.wr_addr = pos_ff;
               ram_req.wr_data = item_ff;
               state_in        = S_DONE;
            end else begin
               ram_req.rd_addr_a = parent_addr;
               state_in          = S_UP_CMP;
            end
         end
         S_UP_CMP: begin
            ram_req.wr_en   = 1'b1;
            ram_req.wr_addr = pos_ff;
            // pass the parent only while strictly lighter
            if ($signed(item_ff.weight) < $signed(rd_data_a.weight)) begin
               ram_req.wr_data = rd_data_a;
               pos_in          = parent_addr;
               state_in        = S_UP_RD;
            end else begin
               ram_req.wr_data = item_ff;
               state_in        = S_DONE;
            end
         end
         S_DN_ROOT: begin
            top_in  = rd_data_a;
            item_in = rd_data_b;
            pos_in  = '0;
            if (count_ff == '0) begin
               state_in = S_DONE;
            end else begin
               state_in = S_DN_RD;
            end
         end
         S_DN_RD: begin
            if (!left_in_heap) begin
               ram_req.wr_en   = 1'b1;
               ram_req.wr_addr = pos_ff;
               ram_req.wr_data = item_ff;
               state_in        = S_DONE;
            end else begin
               ram_req.rd_addr_a = left_idx[ebmh_pkg::ADDR_BITS-1:0];
               ram_req.rd_addr_b = right_idx[ebmh_pkg::ADDR_BITS-1:0];
               state_in          = S_DN_CMP;
            end
         end
         S_DN_CMP: begin
            ram_req.wr_en   = 1'b1;
            ram_req.wr_addr = pos_ff;
            if ($signed(item_ff.weight) > $signed(chosen.weight)) begin
               ram_req.wr_data = chosen;
               pos_in          = chosen_addr;
               state_in        = S_DN_RD;
            end else begin
               ram_req.wr_data = item_ff;
               state_in        = S_DONE;
            end
         end
         S_DONE: begin
            res_valid = 1'b1;
            if (res_take) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   assign res.status    = status_ff;
   assign res.min_edge  = top_ff;
   assign res.occupancy = count_ff;

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
      end
   end

   // working registers
   always_ff @(posedge clock) begin
      pos_ff    <= pos_in;
      item_ff   <= item_in;
      top_ff    <= top_in;
      status_ff <= status_in;
   end

   // occupancy never passes the memory depth
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= ebmh_pkg::COUNT_BITS'(ebmh_pkg::CAPACITY))
      else $error("entry count above capacity");

   // sift writes stay inside the live part of the heap
   a_write_live: assert property (@(posedge clock) disable iff (reset)
      ram_req.wr_en |-> ({1'b0, ram_req.wr_addr} < (ebmh_pkg::ADDR_BITS + 1)'(count_ff)))
      else $error("heap write beyond last entry");

   // one command at a time
   a_one_cmd: assert property (@(posedge clock) disable iff (reset)
      (cmd_valid && cmd_ready) |=> !cmd_ready)
      else $error("command taken while busy");

   // refused commands carry no edge and leave the count alone
   a_refused: assert property (@(posedge clock) disable iff (reset)
      (res_valid && status_ff != ebmh_pkg::STATUS_DONE) |-> (top_ff == '0))
      else $error("refused command returned an edge");

   a_count_step: assert property (@(posedge clock) disable iff (reset)
      (cmd_valid && cmd_ready && is_full && cmd_op == ebmh_pkg::CMD_INSERT)
         |=> $stable(count_ff))
      else $error("full insert changed the count");

endmodule

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 100ps

module tb_top;

   // result word field offsets
   localparam int MIN_V_LO  = 0;
   localparam int MIN_W_LO  = ebmh_pkg::VERTEX_BITS;
   localparam int MIN_WT_LO = 2 * ebmh_pkg::VERTEX_BITS;
   localparam int OCC_LO    = ebmh_pkg::ENTRY_BITS;
   localparam int KEEP_LIMIT = -1;
   localparam int LONG_HOLD_CYCLES = 300;

   logic clock;
   logic reset = 1'b1;

   logic                               req_tvalid = 1'b0;
   logic                               req_tready;
   logic                               req_tuser = ebmh_pkg::CMD_INSERT;
   logic [ebmh_pkg::REQ_DATA_BITS-1:0] req_tdata = '0;
   logic                               rsp_tvalid;
   logic                               rsp_tready = 1'b0;
   logic [ebmh_pkg::STATUS_BITS-1:0]   rsp_tuser;
   logic [ebmh_pkg::RSP_DATA_BITS-1:0] rsp_tdata;
   logic                               csr_psel = 1'b0;
   logic                               csr_penable = 1'b0;
   logic                               csr_pwrite = 1'b0;
   logic [ebmh_pkg::CSR_ADDR_BITS-1:0] csr_paddr = '0;
   logic [ebmh_pkg::CSR_DATA_BITS-1:0] csr_pwdata = '0;
   logic [ebmh_pkg::CSR_DATA_BITS-1:0] csr_prdata;
   logic                               csr_pready;

   edge_binary_min_heap u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tuser   (req_tuser),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tuser   (rsp_tuser),
      .rsp_tdata   (rsp_tdata),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   // heap image kept alongside the block
   typedef struct {
      logic [ebmh_pkg::VERTEX_BITS-1:0]        v;
      logic [ebmh_pkg::VERTEX_BITS-1:0]        w;
      logic signed [ebmh_pkg::WEIGHT_BITS-1:0] weight;
   } heap_slot_type;

   heap_slot_type model_heap [ebmh_pkg::CAPACITY];
   int            model_count = 0;
   int            model_limit = ebmh_pkg::CAPACITY;

   ebmh_pkg::result_type pending_results [$];
   int                   fail_count = 0;
   int                   results_seen = 0;
   bit                   tx_steady = 1'b0;
   int                   items_sent = 0;

   // directed stimulus rows; typed rows carry their expected result
   typedef struct {
      int                               limit_set;
      logic                             cmd;
      logic [ebmh_pkg::VERTEX_BITS-1:0] v;
      logic [ebmh_pkg::VERTEX_BITS-1:0] w;
      logic [ebmh_pkg::WEIGHT_BITS-1:0] wt;
      bit                               typed;
      logic [ebmh_pkg::STATUS_BITS-1:0] st;
      logic [ebmh_pkg::VERTEX_BITS-1:0] mv;
      logic [ebmh_pkg::VERTEX_BITS-1:0] mw;
      logic [ebmh_pkg::WEIGHT_BITS-1:0] mwt;
      int                               occ;
   } dir_row_type;

   dir_row_type dir_rows [25] = '{
      '{KEEP_LIMIT, ebmh_pkg::CMD_DELETE, 16'h0000, 16'h0000, 16'h0000, 1,
        ebmh_pkg::STATUS_EMPTY, 16'h0000, 16'h0000, 16'h0000, 0},
      '{KEEP_LIMIT, ebmh_pkg::CMD_INSERT, 16'h0000, 16'h0000, 16'h7FFF, 1,
        ebmh_pkg::STATUS_DONE, 16'h0000, 16'h0000, 16'h0000, 1},
      '{KEEP_LIMIT, ebmh_pkg::CMD_INSERT, 16'hFFFF, 16'hFFFF, 16'h8000, 1,
        ebmh_pkg::STATUS_DONE, 16'h0000, 16'h0000, 16'h0000, 2},
      '{KEEP_LIMIT, ebmh_pkg::CMD_INSERT, 16'h1234, 16'h4321, 16'h0000, 1,
        ebmh_pkg::STATUS_DONE, 16'h0000, 16'h0000, 16'h0000, 3},
      '{KEEP_LIMIT, ebmh_pkg::CMD_INSERT, 16'hAAAA, 16'h5555, 16'h0000, 1,
        ebmh_pkg::STATUS_DONE, 16'h0000, 16'h0000, 16'h0000, 4},
      '{KEEP_LIMIT, ebmh_pkg::CMD_INSERT, 16'h5555, 16'hAAAA, 16'hFFFF, 1,
        ebmh_pkg::STATUS_DONE, 16'h0000, 16'h0000, 16'h0000, 5},
      '{KEEP_LIMIT, ebmh_pkg::CMD_DELETE, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1,
        ebmh_pkg::STATUS_DONE, 16'hFFFF, 16'hFFFF, 16'h8000, 4},
      '{KEEP_LIMIT, ebmh_pkg::CMD_DELETE, 16'h0000, 16'h0000, 16'h0000, 1,
        ebmh_pkg::STATUS_DONE, 16'h5555, 16'hAAAA, 16'hFFFF, 3},
      // tie between the two zero weights: order set by the heap shape
      '{KEEP_LIMIT, ebmh_pkg::CMD_DELETE, 16'h0000, 16'h0000, 16'h0000, 0,
        ebmh_pkg::STATUS_DONE, 16'h0000, 16'h0000, 16'h0000, 0},
      '{KEEP_LIMIT, ebmh_pkg::CMD_DELETE, 16'h0000, 16'h0000, 16'h0000, 0,
        ebmh_pkg::STATUS_DONE, 16'h0000, 16'h0000, 16'h0000, 0},
      '{KEEP_LIMIT, ebmh_pkg::CMD_DELETE, 16'h0000, 16'h0000, 16'h0000, 1,
        ebmh_pkg::STATUS_DONE, 16'h0000, 16'h0000, 16'h7FFF, 0},
      '{KEEP_LIMIT, ebmh_pkg::CMD_DELETE, 16'h0000, 16'h0000, 16'h0000, 1,
        ebmh_pkg::STATUS_EMPTY, 16'h0000, 16'h0000, 16'h0000, 0},
      // run of equal weights
      '{KEEP_LIMIT, ebmh_pkg::CMD_INSERT, 16'h0001, 16'h0010, 16'h0007, 0,
        ebmh_pkg::STATUS_DONE, 16'h0000, 16'h0000, 16'h0000, 0},
      '{KEEP_LIMIT, ebmh_pkg::CMD_INSERT, 16'h0002, 16'h0020, 16'h0007, 0,
        ebmh_pkg::STATUS_DONE, 16'h0000, 16'h0000, 16'h0000, 0},
      '{KEEP_LIMIT, ebmh_pkg::CMD_INSERT, 16'h0003, 16'h0030, 16'h0007, 0,
        ebmh_pkg::STATUS_DONE, 16'h0000, 16'h0000, 16'h0000, 0},
      '{KEEP_LIMIT, ebmh_pkg::CMD_INSERT, 16'h0004, 16'h0040, 16'h0007, 0,
        ebmh_pkg::STATUS_DONE, 16'h0000, 16'h0000, 16'h0000, 0},
      '{KEEP_LIMIT, ebmh_pkg::CMD_DELETE, 16'h0000, 16'h0000, 16'h0000, 0,
        ebmh_pkg::STATUS_DONE, 16'h0000, 16'h0000, 16'h0000, 0},
      '{KEEP_LIMIT, ebmh_pkg::CMD_DELETE, 16'h0000, 16'h0000, 16'h0000, 0,
        ebmh_pkg::STATUS_DONE, 16'h0000, 16'h0000, 16'h0000, 0},
      '{KEEP_LIMIT, ebmh_pkg::CMD_DELETE, 16'h0000, 16'h0000, 16'h0000, 0,
        ebmh_pkg::STATUS_DONE, 16'h0000, 16'h0000, 16'h0000, 0},
      '{KEEP_LIMIT, ebmh_pkg::CMD_DELETE, 16'h0000, 16'h0000, 16'h0000, 0,
        ebmh_pkg::STATUS_DONE, 16'h0000, 16'h0000, 16'h0000, 0},
      // zero limit refuses every insert
      '{0, ebmh_pkg::CMD_INSERT, 16'h0001, 16'h0002, 16'h0003, 1,
        ebmh_pkg::STATUS_FULL, 16'h0000, 16'h0000, 16'h0000, 0},
      '{KEEP_LIMIT, ebmh_pkg::CMD_DELETE, 16'h0000, 16'h0000, 16'h0000, 1,
        ebmh_pkg::STATUS_EMPTY, 16'h0000, 16'h0000, 16'h0000, 0},
      // limit above the heap size acts as the heap size
      '{2047, ebmh_pkg::CMD_INSERT, 16'h5A5A, 16'hA5A5, 16'h7FFE, 0,
        ebmh_pkg::STATUS_DONE, 16'h0000, 16'h0000, 16'h0000, 0},
      // limit lowered to the occupancy
      '{1, ebmh_pkg::CMD_INSERT, 16'h0001, 16'h0001, 16'h0001, 1,
        ebmh_pkg::STATUS_FULL, 16'h0000, 16'h0000, 16'h0000, 1},
      '{KEEP_LIMIT, ebmh_pkg::CMD_DELETE, 16'h0000, 16'h0000, 16'h0000, 1,
        ebmh_pkg::STATUS_DONE, 16'h5A5A, 16'hA5A5, 16'h7FFE, 0}
   };

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // apply one command to the heap image, return the result it produces
   function automatic ebmh_pkg::result_type heap_apply_cmd(
         input logic                                    cmd,
         input logic [ebmh_pkg::VERTEX_BITS-1:0]        v,
         input logic [ebmh_pkg::VERTEX_BITS-1:0]        w,
         input logic signed [ebmh_pkg::WEIGHT_BITS-1:0] wt);
      ebmh_pkg::result_type res;
      heap_slot_type        item;
      heap_slot_type        top;
      int                   pos;
      int                   parent;
      int                   child;
      int                   n;
      int                   lim;
      bit                   done;
      res = '0;
      lim = (model_limit < ebmh_pkg::CAPACITY) ? model_limit : ebmh_pkg::CAPACITY;
      if (cmd == ebmh_pkg::CMD_INSERT) begin
         if (model_count >= lim) begin
            res.status = ebmh_pkg::STATUS_FULL;
         end else begin
            // sift up, stop on equal weight
            item.v = v;
            item.w = w;
            item.weight = wt;
            pos = model_count;
            done = 1'b0;
            while (pos > 0 && !done) begin
               parent = (pos - 1) / 2;
               if (item.weight < model_heap[parent].weight) begin
                  model_heap[pos] = model_heap[parent];
                  pos = parent;
               end else begin
                  done = 1'b1;
               end
            end
            model_heap[pos] = item;
            model_count++;
         end
      end else if (model_count == 0) begin
         res.status = ebmh_pkg::STATUS_EMPTY;
      end else begin
         top = model_heap[0];
         n = model_count - 1;
         res.status = ebmh_pkg::STATUS_DONE;
         res.min_edge.v = top.v;
         res.min_edge.w = top.w;
         res.min_edge.weight = top.weight;
         // last entry to the root, sift down; right child only if left is heavier
         if (n > 0) begin
            item = model_heap[n];
            pos = 0;
            done = 1'b0;
            while (!done) begin
               child = 2 * pos + 1;
               if (child >= n) begin
                  done = 1'b1;
               end else begin
                  if (child + 1 < n && model_heap[child].weight > model_heap[child + 1].weight)
                     child++;
                  if (item.weight > model_heap[child].weight) begin
                     model_heap[pos] = model_heap[child];
                     pos = child;
                  end else begin
                     done = 1'b1;
                  end
               end
            end
            model_heap[pos] = item;
         end
         model_count = n;
      end
      res.occupancy = ebmh_pkg::COUNT_BITS'(model_count);
      return res;
   endfunction

   // offer one command word, record its expected result once accepted
   task automatic send_cmd(input logic cmd, input logic [ebmh_pkg::VERTEX_BITS-1:0] v,
                           input logic [ebmh_pkg::VERTEX_BITS-1:0] w,
                           input logic [ebmh_pkg::WEIGHT_BITS-1:0] wt,
                           input bit typed, input ebmh_pkg::result_type typed_res);
      int                   gap;
      int                   pick;
      ebmh_pkg::result_type pred;
      gap = 0;
      if (!tx_steady) begin
         pick = $urandom_range(0, 99);
         if (pick >= 92)
            gap = $urandom_range(8, 40);
         else if (pick >= 70)
            gap = $urandom_range(1, 3);
      end
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= cmd;
      req_tdata  <= ebmh_pkg::REQ_DATA_BITS'({wt, w, v});
      do @(posedge clock); while (!req_tready);
      pred = heap_apply_cmd(cmd, v, w, wt);
      pending_results.push_back(typed ? typed_res : pred);
      items_sent++;
      if (items_sent % 64 == 0)
         tx_steady = ($urandom_range(0, 3) == 0);
   endtask

   task automatic send_random(input int delete_pct);
      logic [ebmh_pkg::WEIGHT_BITS-1:0] wt;
      logic                             cmd;
      cmd = ($urandom_range(0, 99) < delete_pct) ? ebmh_pkg::CMD_DELETE : ebmh_pkg::CMD_INSERT;
      // narrow weights now and then to force ties
      if ($urandom_range(0, 3) == 0)
         wt = ebmh_pkg::WEIGHT_BITS'($urandom_range(0, 8) - 4);
      else
         wt = ebmh_pkg::WEIGHT_BITS'($urandom);
      send_cmd(cmd, ebmh_pkg::VERTEX_BITS'($urandom), ebmh_pkg::VERTEX_BITS'($urandom), wt,
               1'b0, '0);
   endtask

   task automatic wait_drained();
      req_tvalid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
   endtask

   // limit change: only with the heap engine idle; read back afterwards
   task automatic apply_capacity_limit(input int lim);
      logic [ebmh_pkg::CSR_DATA_BITS-1:0] rd;
      wait_drained();
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= ebmh_pkg::CSR_CAPACITY_LIMIT;
      csr_pwdata  <= ebmh_pkg::CSR_DATA_BITS'(lim);
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      model_limit = lim;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      rd = csr_prdata;
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      if (rd !== ebmh_pkg::CSR_DATA_BITS'(lim)) begin
         $error("capacity_limit mismatch: expected %0d, got %0d", lim, rd);
         fail_count++;
      end
   endtask

   task automatic check_field(input string name, input logic [31:0] exp_val,
                              input logic [31:0] got_val);
      if (got_val !== exp_val) begin
         $error("%s mismatch: expected 0x%0h, got 0x%0h", name, exp_val, got_val);
         fail_count++;
      end
   endtask

   // result side: compare each word, random back-pressure, one long hold
   int                   rx_stall_left = 0;
   int                   rx_hold_left = 0;
   bit                   rx_hold_done = 1'b0;
   bit                   rx_steady = 1'b0;
   int                   rx_cycles = 0;
   ebmh_pkg::result_type want;

   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (pending_results.size() == 0) begin
               $error("unexpected result word: status %0d, data 0x%0h", rsp_tuser, rsp_tdata);
               fail_count++;
            end else begin
               want = pending_results.pop_front();
               check_field("status", 32'(want.status), 32'(rsp_tuser));
               check_field("min_v", 32'(want.min_edge.v),
                           32'(rsp_tdata[MIN_V_LO +: ebmh_pkg::VERTEX_BITS]));
               check_field("min_w", 32'(want.min_edge.w),
                           32'(rsp_tdata[MIN_W_LO +: ebmh_pkg::VERTEX_BITS]));
               check_field("min_weight", 32'($unsigned(want.min_edge.weight)),
                           32'(rsp_tdata[MIN_WT_LO +: ebmh_pkg::WEIGHT_BITS]));
               check_field("occupancy", 32'(want.occupancy),
                           32'(rsp_tdata[OCC_LO +: ebmh_pkg::COUNT_BITS]));
            end
            results_seen++;
            if (results_seen == 40 && !rx_hold_done) begin
               rx_hold_left = LONG_HOLD_CYCLES;
               rx_hold_done = 1'b1;
            end
         end
         rx_cycles++;
         if (rx_cycles % 256 == 0)
            rx_steady = ($urandom_range(0, 3) == 0);
         if (rx_hold_left > 0) begin
            rsp_tready <= 1'b0;
            rx_hold_left--;
         end else if (rx_stall_left > 0) begin
            rsp_tready <= 1'b0;
            rx_stall_left--;
         end else begin
            rsp_tready <= 1'b1;
            if (!rx_steady && $urandom_range(0, 99) < 25)
               rx_stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40)
                                                           : $urandom_range(1, 3);
         end
      end
   end

   // stimulus
   int                   fill_extra;
   int                   fill_items;
   ebmh_pkg::result_type typed_res;

   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed rows
      foreach (dir_rows[i]) begin
         if (dir_rows[i].limit_set != KEEP_LIMIT)
            apply_capacity_limit(dir_rows[i].limit_set);
         typed_res = '0;
         typed_res.status = dir_rows[i].st;
         typed_res.min_edge.v = dir_rows[i].mv;
         typed_res.min_edge.w = dir_rows[i].mw;
         typed_res.min_edge.weight = dir_rows[i].mwt;
         typed_res.occupancy = ebmh_pkg::COUNT_BITS'(dir_rows[i].occ);
         send_cmd(dir_rows[i].cmd, dir_rows[i].v, dir_rows[i].w, dir_rows[i].wt,
                  dir_rows[i].typed, typed_res);
      end

      // small limit: full and empty come often; the long receiver hold lands here
      apply_capacity_limit(6);
      repeat (30) send_random(50);

      // fill to the full depth with the limit above the heap size, then overrun
      apply_capacity_limit(2047);
      fill_extra = 0;
      fill_items = 0;
      while (fill_extra < 3) begin
         if (model_count >= ebmh_pkg::CAPACITY)
            fill_extra++;
         send_random(0);
         fill_items++;
         if (fill_items == 500)
            wait_drained();
      end

      // limit lowered below occupancy: inserts refused, deletes go on
      apply_capacity_limit(100);
      repeat (20) send_random(70);

      wait_drained();
      repeat (60) @(posedge clock);
      if (fail_count == 0)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end

   // watchdog
   initial begin
      #5_000_000;
      $display("TEST FAILED");
      $finish;
   end

endmodule
